// ===== hw/rtl/decimal_seven_segment_writer_top_assert.svh =====
// Assertion macros for the decimal seven-segment writer top level.
`ifndef DECIMAL_SEVEN_SEGMENT_WRITER_TOP_ASSERT_SVH
`define DECIMAL_SEVEN_SEGMENT_WRITER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DSSW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dssw same-cycle check failed");

// next-cycle implication, checked out of reset
`define DSSW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dssw next-cycle check failed");

`endif

// ===== hw/rtl/dssw_pkg.sv =====
// Package with widths, register addresses and segment table of the seven-segment writer.
package dssw_pkg;

  localparam int unsigned NumberW  = 16;
  localparam int unsigned SatW     = 14;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned RegW     = 3;
  localparam int unsigned SegW     = 8;
  localparam int unsigned NumWr    = 4;
  localparam int unsigned WrIdxW   = 2;
  localparam int unsigned OutDataW = 16;

  localparam logic [SatW-1:0] SatLimit = 14'd9999;

  localparam logic [14:0] Recip1000 = 15'd16778;
  localparam logic [13:0] Recip100  = 14'd10486;
  localparam logic [13:0] Recip10   = 14'd13108;

  localparam logic [RegW-1:0] RegThousands = 3'd3;
  localparam logic [RegW-1:0] RegHundreds  = 3'd2;
  localparam logic [RegW-1:0] RegTens      = 3'd1;
  localparam logic [RegW-1:0] RegOnes      = 3'd4;

  localparam logic [WrIdxW-1:0] LastWr = 2'd3;

  typedef logic [NumWr-1:0][SegW-1:0] seg_set_t;

  function automatic logic [SegW-1:0] seg_of(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] seg;
    case (digit)
      4'd0: seg = 8'h7E;
      4'd1: seg = 8'h30;
      4'd2: seg = 8'h6D;
      4'd3: seg = 8'h79;
      4'd4: seg = 8'h33;
      4'd5: seg = 8'h5B;
      4'd6: seg = 8'h5F;
      4'd7: seg = 8'h70;
      4'd8: seg = 8'h7F;
      4'd9: seg = 8'h7B;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  function automatic logic [RegW-1:0] reg_of(input logic [WrIdxW-1:0] idx);
    logic [RegW-1:0] addr;
    case (idx)
      2'd0: addr = RegThousands;
      2'd1: addr = RegHundreds;
      2'd2: addr = RegTens;
      default: addr = RegOnes;
    endcase
    return addr;
  endfunction

endpackage

// ===== hw/rtl/dssw_convert.sv =====
// Saturation, decimal digit split and segment lookup for one number.
module dssw_convert (
  input  logic [dssw_pkg::NumberW-1:0] number_i,
  output dssw_pkg::seg_set_t           segs_o
);

  logic [dssw_pkg::SatW-1:0]   sat;
  logic [28:0]                 p1000;
  logic [27:0]                 p100;
  logic [27:0]                 p10;
  logic [3:0]                  q1000;
  logic [6:0]                  q100;
  logic [9:0]                  q10;
  logic [6:0]                  r2;
  logic [9:0]                  r1;
  logic [dssw_pkg::SatW-1:0]   r0;

  always_comb begin
    if (number_i > dssw_pkg::NumberW'(dssw_pkg::SatLimit)) begin
      sat = dssw_pkg::SatLimit;
    end else begin
      sat = number_i[dssw_pkg::SatW-1:0];
    end
  end

  assign p1000 = 29'(sat) * 29'(dssw_pkg::Recip1000);
  assign p100  = 28'(sat) * 28'(dssw_pkg::Recip100);
  assign p10   = 28'(sat) * 28'(dssw_pkg::Recip10);

  assign q1000 = p1000[27:24];
  assign q100  = p100[26:20];
  assign q10   = p10[26:17];

  assign r2 = q100 - (7'(q1000) << 3) - (7'(q1000) << 1);
  assign r1 = q10 - (10'(q100) << 3) - (10'(q100) << 1);
  assign r0 = sat - (14'(q10) << 3) - (14'(q10) << 1);

  assign segs_o[0] = dssw_pkg::seg_of(q1000);
  assign segs_o[1] = dssw_pkg::seg_of(r2[dssw_pkg::DigitW-1:0]);
  assign segs_o[2] = dssw_pkg::seg_of(r1[dssw_pkg::DigitW-1:0]);
  assign segs_o[3] = dssw_pkg::seg_of(r0[dssw_pkg::DigitW-1:0]);

endmodule

// ===== hw/rtl/dssw_out_seq.sv =====
// Result register and write sequencer that emits four register writes per number.
module dssw_out_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  dssw_pkg::seg_set_t            segs_i,
  output logic                          free_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [2:0] digit_register, [10:3] segment_byte, [15:11] zero
  output logic [dssw_pkg::OutDataW-1:0] m_axis_tdata_o,
  // last_write
  output logic                          m_axis_tlast_o
);

  dssw_pkg::seg_set_t              segs_q;
  logic                            vld_q, vld_d;
  logic [dssw_pkg::WrIdxW-1:0]     idx_q, idx_d;
  logic                            xfer;
  logic                            last;

  assign last   = (idx_q == dssw_pkg::LastWr);
  assign xfer   = vld_q && m_axis_tready_i;
  assign free_o = !vld_q || (xfer && last);

  always_comb begin
    vld_d = vld_q;
    idx_d = idx_q;
    if (xfer) begin
      idx_d = idx_q + 2'd1;
      if (last) begin
        vld_d = 1'b0;
      end
    end
    if (load_i) begin
      vld_d = 1'b1;
      idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      segs_q <= segs_i;
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tlast_o  = last;
  assign m_axis_tdata_o  = {5'b0, segs_q[idx_q], dssw_pkg::reg_of(idx_q)};

endmodule

// ===== hw/rtl/decimal_seven_segment_writer_top.sv =====
// Top level of the four-digit decimal seven-segment register writer.
//
//  channel   dir  payload
//  s_axis    in   tdata[15:0] number
//  m_axis    out  tdata[2:0] digit_register, tdata[10:3] segment_byte, tlast last_write
//
// Each number yields four write transfers, one per cycle on m_axis while tready is high,
// in the order thousands, hundreds, tens, ones; the sustained rate is set by the single
// output channel. The first write becomes valid once the number has passed the input
// register and then been loaded into the result register once that is free. An input
// register and a result register decouple the sides, so s_axis stays ready while the
// input register is free. Reset clears control only.
module decimal_seven_segment_writer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [15:0] number
  input  logic [dssw_pkg::NumberW-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [2:0] digit_register, [10:3] segment_byte, [15:11] zero
  output logic [dssw_pkg::OutDataW-1:0] m_axis_tdata_o,
  // last_write
  output logic                          m_axis_tlast_o
);

  logic                          in_vld_q, in_vld_d;
  logic [dssw_pkg::NumberW-1:0]  in_num_q;
  logic                          in_xfer;
  logic                          out_xfer;
  logic                          load;
  logic                          res_free;
  dssw_pkg::seg_set_t            segs;

  assign load            = in_vld_q && res_free;
  assign s_axis_tready_o = !in_vld_q || load;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer        = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    in_vld_d = in_vld_q;
    if (load) begin
      in_vld_d = 1'b0;
    end
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_num_q <= s_axis_tdata_i;
    end
  end

  dssw_convert u_convert (
    .number_i (in_num_q),
    .segs_o   (segs)
  );

  dssw_out_seq u_out_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .segs_i          (segs),
    .free_o          (res_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

`include "decimal_seven_segment_writer_top_assert.svh"

  `DSSW_ASSERT_NEXT(a_in_captured, in_xfer, in_vld_q)
  `DSSW_ASSERT_NEXT(a_writes_pending, out_xfer && !m_axis_tlast_o, m_axis_tvalid_o)
  `DSSW_ASSERT_NOW(a_stall_only_full, !s_axis_tready_o, in_vld_q && m_axis_tvalid_o)

endmodule

// ===== test/dssw_checker.sv =====
// Checker that predicts the digit register writes of each number and compares them.
`timescale 1ns / 100ps

module dssw_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  input  logic [dssw_pkg::NumberW-1:0]  s_axis_tdata_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  input  logic [dssw_pkg::OutDataW-1:0] m_axis_tdata_i,
  input  logic                          m_axis_tlast_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   open_writes_o
);

  typedef struct packed {
    logic [dssw_pkg::RegW-1:0] reg_addr;
    logic [dssw_pkg::SegW-1:0] pattern;
    logic                      last;
  } digit_write_t;

  localparam logic [9:0][7:0] DigitPattern = {
    8'h7B, 8'h7F, 8'h70, 8'h5F, 8'h5B, 8'h33, 8'h79, 8'h6D, 8'h30, 8'h7E
  };

  digit_write_t pending_writes[$];
  int unsigned  fails = 0;
  int unsigned  open_cnt = 0;

  assign fail_count_o  = fails;
  assign open_writes_o = open_cnt;

  task automatic queue_display_writes(input logic [dssw_pkg::NumberW-1:0] number);
    int unsigned shown;
    int unsigned digit [4];
    logic [dssw_pkg::RegW-1:0] addr [4];
    digit_write_t wr;
    shown = 32'(number);
    if (shown > dssw_pkg::SatLimit) shown = 32'(dssw_pkg::SatLimit);
    digit[0] = shown / 1000;
    digit[1] = (shown / 100) % 10;
    digit[2] = (shown / 10) % 10;
    digit[3] = shown % 10;
    addr[0] = dssw_pkg::RegThousands;
    addr[1] = dssw_pkg::RegHundreds;
    addr[2] = dssw_pkg::RegTens;
    addr[3] = dssw_pkg::RegOnes;
    for (int k = 0; k < 4; k++) begin
      wr.reg_addr = addr[k];
      wr.pattern  = DigitPattern[digit[k]];
      wr.last     = (k == 3);
      pending_writes.push_back(wr);
    end
  endtask

  always @(posedge clk_i) begin : watch
    digit_write_t want;
    logic [dssw_pkg::RegW-1:0] got_addr;
    logic [dssw_pkg::SegW-1:0] got_pattern;
    logic [dssw_pkg::OutDataW-dssw_pkg::RegW-dssw_pkg::SegW-1:0] got_pad;
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got_addr    = m_axis_tdata_i[dssw_pkg::RegW-1:0];
        got_pattern = m_axis_tdata_i[dssw_pkg::RegW +: dssw_pkg::SegW];
        got_pad     = m_axis_tdata_i[dssw_pkg::OutDataW-1:dssw_pkg::RegW+dssw_pkg::SegW];
        if (pending_writes.size() == 0) begin
          $display("%0t: unexpected write: expected none, actual tdata %h tlast %b",
                   $time, m_axis_tdata_i, m_axis_tlast_i);
          fails = fails + 1;
        end else begin
          want = pending_writes.pop_front();
          if (got_addr !== want.reg_addr) begin
            $display("%0t: digit_register: expected %0d, actual %0d",
                     $time, want.reg_addr, got_addr);
            fails = fails + 1;
          end
          if (got_pattern !== want.pattern) begin
            $display("%0t: segment_byte: expected %h, actual %h",
                     $time, want.pattern, got_pattern);
            fails = fails + 1;
          end
          if (m_axis_tlast_i !== want.last) begin
            $display("%0t: last_write: expected %b, actual %b",
                     $time, want.last, m_axis_tlast_i);
            fails = fails + 1;
          end
          if (got_pad !== '0) begin
            $display("%0t: tdata padding: expected 0, actual %h", $time, got_pad);
            fails = fails + 1;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) queue_display_writes(s_axis_tdata_i);
    end
    open_cnt = pending_writes.size();
  end

endmodule

// ===== test/tb_decimal_seven_segment_writer_top.sv =====
// Testbench top: drives numbers and receiver stalls, and reports the verdict.
`timescale 1ns / 100ps

module tb_decimal_seven_segment_writer_top;

  localparam int NumRandom  = 200;
  localparam int EagerFrom  = 60;
  localparam int EagerTo    = 100;
  localparam int HoldAt     = 120;
  localparam int HoldCycles = 120;
  localparam int CalmFrom   = 400;
  localparam int CalmTo     = 520;
  localparam int NumFixed   = 22;

  localparam logic [NumFixed-1:0][15:0] FixedNumbers = {
    16'd0, 16'd9999, 16'd10000, 16'd65535, 16'd1, 16'd9, 16'd10, 16'd99,
    16'd100, 16'd999, 16'd1000, 16'd1234, 16'd5678, 16'd9990, 16'd8765,
    16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF, 16'd4321, 16'd9998, 16'd2020
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [dssw_pkg::NumberW-1:0]  s_axis_tdata_i = '0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [dssw_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic                          m_axis_tlast_o;
  int unsigned                   fail_count;
  int unsigned                   open_writes;

  always #10 clk_i = ~clk_i;

  decimal_seven_segment_writer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  dssw_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .fail_count_o    (fail_count),
    .open_writes_o   (open_writes)
  );

  task automatic offer_number(input logic [15:0] value, input bit eager);
    int   gap;
    logic fire;
    gap = eager ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    do begin
      @(negedge clk_i);
      fire = s_axis_tready_o;
      @(posedge clk_i);
    end while (!fire);
  endtask

  initial begin : stimulus
    int          pick;
    logic [15:0] value;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumFixed; i++) offer_number(FixedNumbers[i], 1'b0);
    for (int i = 0; i < NumRandom; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) value = 16'($urandom_range(0, 9999));
      else if (pick < 17) value = 16'($urandom_range(10000, 65535));
      else value = 16'($urandom());
      offer_number(value, i >= EagerFrom && i < EagerTo);
    end
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (open_writes != 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : write_sink
    int   stall;
    int   taken;
    logic fire;
    taken = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (taken == HoldAt) stall = HoldCycles;
      else if (taken >= CalmFrom && taken < CalmTo) stall = 0;
      else stall = $urandom_range(0, 8);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        fire = m_axis_tvalid_o;
        @(posedge clk_i);
      end while (!fire);
      taken++;
    end
  end

  initial begin : watchdog
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
